FILE: rtl/cctb_pkg.sv
// ----------------------------------------------------------------------------
// Chained countdown timer bank package
// Shared types and constants: opcodes, timer modes, the per-timer record held
// in memory, the transfer payloads and the record update status.
// ----------------------------------------------------------------------------
package cctb_pkg;

  // Largest value a seconds or minutes field reloads to on a borrow.
  localparam logic [5:0] SEC_MAX = 6'd59;
  localparam logic [5:0] MIN_MAX = 6'd59;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_TIME   = 3'd1,
    OP_START      = 3'd2,
    OP_STOP       = 3'd3,
    OP_PLAY_PAUSE = 3'd4,
    OP_SET_SUCC   = 3'd5,
    OP_CLR_PEND   = 3'd6
  } cctb_op_e;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } cctb_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_RB,
    ST_CMD,
    ST_FIN
  } cctb_state_e;

  typedef struct packed {
    logic [6:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } cctb_hms_t;

  // One timer. The all-zero record is the reset value: stopped, zero time,
  // no successor. Successor bit 4 is the valid flag, bits 3..0 the index.
  typedef struct packed {
    logic [4:0] succ;
    cctb_mode_e mode;
    cctb_hms_t  preset;
    cctb_hms_t  current;
  } cctb_rec_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] index;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] next_timer;
    logic       has_next;
  } cctb_in_t;

  typedef struct packed {
    logic [15:0] expired_mask;
    logic        pending;
    logic [3:0]  pending_index;
    logic [15:0] running_mask;
    logic [4:0]  running_count;
    logic [1:0]  sel_state;
    logic [6:0]  sel_hours;
    logic [5:0]  sel_minutes;
    logic [5:0]  sel_seconds;
  } cctb_out_t;

  // Status of one record update, passed from the update unit to the control.
  typedef struct packed {
    logic wr;
    logic expired;
    logic run_set;
    logic run_clr;
  } cctb_upd_st_t;

endpackage

FILE: rtl/cctb_if.sv
// ----------------------------------------------------------------------------
// Chained countdown timer bank channels
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface cctb_in_if;
  import cctb_pkg::*;

  logic     valid;
  logic     ready;
  cctb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cctb_out_if;
  import cctb_pkg::*;

  logic      valid;
  logic      ready;
  cctb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/cctb_rec_mem.sv
// ----------------------------------------------------------------------------
// Timer record memory
// Single write port, single read port, registered read data. Entries that
// were never written since reset read as the reset record.
// ----------------------------------------------------------------------------
module cctb_rec_mem #(
  parameter int TIMERS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       we_i,
  input  logic [((TIMERS > 1) ? $clog2(TIMERS) : 1)-1:0] waddr_i,
  input  cctb_pkg::cctb_rec_t                        wdata_i,
  input  logic                                       re_i,
  input  logic [((TIMERS > 1) ? $clog2(TIMERS) : 1)-1:0] raddr_i,
  output cctb_pkg::cctb_rec_t                        rdata_o
);
  import cctb_pkg::*;

  cctb_rec_t         mem_q [TIMERS];
  cctb_rec_t         data_q;
  logic [TIMERS-1:0] vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      data_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? data_q : '0;

endmodule

FILE: rtl/cctb_rec_upd.sv
// ----------------------------------------------------------------------------
// Timer record update
// Computes the new record for one timer: either the one-second decrement with
// borrow and expiry, or the effect of an addressed command.
// ----------------------------------------------------------------------------
module cctb_rec_upd (
  input  cctb_pkg::cctb_rec_t    rec_i,
  input  logic                   dec_i,
  input  logic                   ok_i,
  input  logic [3:0]             slot_i,
  input  cctb_pkg::cctb_in_t     cmd_i,
  output cctb_pkg::cctb_rec_t    rec_o,
  output cctb_pkg::cctb_upd_st_t st_o
);
  import cctb_pkg::*;

  logic self_succ;

  assign self_succ = rec_i.succ[4] && (rec_i.succ[3:0] == slot_i);

  always_comb begin
    rec_o = rec_i;
    st_o  = '0;
    if (dec_i) begin
      if (rec_i.mode == MODE_RUN) begin
        st_o.wr = 1'b1;
        if (rec_i.current.s != '0) begin
          rec_o.current.s = rec_i.current.s - 6'd1;
        end else if (rec_i.current.m != '0) begin
          rec_o.current.s = SEC_MAX;
          rec_o.current.m = rec_i.current.m - 6'd1;
        end else if (rec_i.current.h != '0) begin
          rec_o.current.s = SEC_MAX;
          rec_o.current.m = MIN_MAX;
          rec_o.current.h = rec_i.current.h - 7'd1;
        end else begin
          // Expiry: reload, and restart at once when the timer is its own
          // successor.
          rec_o.current = rec_i.preset;
          rec_o.mode    = self_succ ? MODE_RUN : MODE_STOP;
          st_o.expired  = 1'b1;
          st_o.run_set  = self_succ;
          st_o.run_clr  = !self_succ;
        end
      end
    end else if (ok_i) begin
      unique case (cctb_op_e'(cmd_i.opcode))
        OP_SET_TIME: begin
          rec_o.preset  = '{h: cmd_i.hours, m: cmd_i.minutes, s: cmd_i.seconds};
          rec_o.current = '{h: cmd_i.hours, m: cmd_i.minutes, s: cmd_i.seconds};
          st_o.wr       = 1'b1;
        end
        OP_START: begin
          rec_o.mode   = MODE_RUN;
          st_o.run_set = 1'b1;
          st_o.wr      = 1'b1;
        end
        OP_STOP: begin
          rec_o.mode    = MODE_STOP;
          rec_o.current = rec_i.preset;
          st_o.run_clr  = 1'b1;
          st_o.wr       = 1'b1;
        end
        OP_PLAY_PAUSE: begin
          if (rec_i.mode == MODE_RUN) begin
            rec_o.mode = MODE_PAUSE;
            st_o.wr    = 1'b1;
          end else if (rec_i.mode == MODE_PAUSE) begin
            rec_o.mode   = MODE_RUN;
            st_o.run_set = 1'b1;
            st_o.wr      = 1'b1;
          end
        end
        OP_SET_SUCC: begin
          rec_o.succ = cmd_i.has_next ? {1'b1, cmd_i.next_timer} : 5'd0;
          st_o.wr    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/chained_countdown_timer_bank_core.sv
// ----------------------------------------------------------------------------
// Chained countdown timer bank core
// Bank of hours:minutes:seconds countdown timers with successor chaining.
// ----------------------------------------------------------------------------
// Each input transfer carries one command and produces exactly one result
// transfer. Timer records (preset, current time, mode, successor) live in a
// single-port-read, single-port-write memory with a registered read port,
// so every command is a read, modify and write of one record. Commands other
// than a tick pass through the command and finish states only. A tick while
// any timer is active first walks the bank one record per cycle through the
// memory read port, then reads back the addressed record; a tick with no
// active timer goes straight to the command state. No clearing pass follows
// reset: per-entry valid bits make unwritten records read as stopped, zero
// time and no successor, so the block is ready right after reset. The result
// register lets a new command be accepted while the previous result waits.
// ----------------------------------------------------------------------------
module chained_countdown_timer_bank_core #(
  parameter int TIMERS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cctb_in_if.sink    in_i,
  cctb_out_if.source out_o
);
  import cctb_pkg::*;

  localparam int         AW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [4:0] NUM  = 5'(TIMERS);
  localparam logic [AW-1:0] LAST = AW'(TIMERS - 1);

  cctb_state_e       state_q, state_d;
  logic [AW-1:0]     p_q, p_d;
  logic [TIMERS-1:0] running_q, running_d;
  // A set bit marks a record whose mode in memory is stale and is really
  // running: a successor started by an expiry is not written back directly.
  logic [TIMERS-1:0] force_q, force_d;
  logic [TIMERS-1:0] exp_q, exp_d;
  logic              pend_vld_q, pend_vld_d;
  logic [3:0]        pend_slot_q, pend_slot_d;
  cctb_in_t          item_q, item_d;
  logic              ok_q, ok_d;
  cctb_out_t         res_q, res_d;
  cctb_out_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr;
  cctb_rec_t         mem_rdata;
  cctb_rec_t         eff_rec, upd_rec;
  cctb_upd_st_t      upd_st;
  logic              walking, acting, in_ok;
  logic [AW-1:0]     slot_addr, idx_addr, sc_addr;
  logic              succ_go;
  logic [4:0]        run_cnt;

  assign walking  = (state_q == ST_WALK);
  assign acting   = walking || ((state_q == ST_CMD) && ok_q);
  assign idx_addr = item_q.index[AW-1:0];
  assign slot_addr = walking ? p_q : idx_addr;
  assign in_ok    = ({1'b0, in_i.data.index} < NUM);

  // The record of the timer being processed, with the pending run override
  // applied.
  always_comb begin
    eff_rec = mem_rdata;
    if (acting && force_q[slot_addr]) begin
      eff_rec.mode = MODE_RUN;
    end
  end

  cctb_rec_mem #(
    .TIMERS (TIMERS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (slot_addr),
    .wdata_i (upd_rec),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cctb_rec_upd u_upd (
    .rec_i  (eff_rec),
    .dec_i  (walking),
    .ok_i   (ok_q),
    .slot_i (4'(slot_addr)),
    .cmd_i  (item_q),
    .rec_o  (upd_rec),
    .st_o   (upd_st)
  );

  // An expiring timer starts its successor when the successor is valid, lies
  // inside the bank and is not the timer itself (that case is handled in the
  // update unit).
  assign sc_addr = eff_rec.succ[AW-1:0];
  assign succ_go = walking && upd_st.expired && eff_rec.succ[4] &&
                   ({1'b0, eff_rec.succ[3:0]} < NUM) &&
                   (eff_rec.succ[3:0] != 4'(p_q));

  always_comb begin
    run_cnt = '0;
    for (int i = 0; i < TIMERS; i++) begin
      run_cnt = run_cnt + 5'(running_d[i]);
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    running_d   = running_q;
    force_d     = force_q;
    exp_d       = exp_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    item_d      = item_q;
    ok_d        = ok_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    mem_re      = 1'b0;
    mem_raddr   = p_q;
    mem_we      = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    // Record write-back and running bit upkeep for the timer in hand.
    if (acting) begin
      if (upd_st.wr) begin
        mem_we             = 1'b1;
        force_d[slot_addr] = 1'b0;
      end
      if (upd_st.run_clr) begin
        running_d[slot_addr] = 1'b0;
      end
      if (upd_st.run_set) begin
        running_d[slot_addr] = 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          item_d = in_i.data;
          ok_d   = in_ok;
          exp_d  = '0;
          if ((cctb_op_e'(in_i.data.opcode) == OP_TICK) && (|running_q)) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            p_d       = '0;
            state_d   = ST_WALK;
          end else begin
            mem_re    = in_ok;
            mem_raddr = in_i.data.index[AW-1:0];
            state_d   = ST_CMD;
          end
        end
      end
      ST_WALK: begin
        if (upd_st.expired) begin
          exp_d[p_q]  = 1'b1;
          pend_vld_d  = 1'b1;
          pend_slot_d = 4'(p_q);
        end
        // A successor with a higher index is read later in this walk and
        // sees the override; a lower one keeps it until its next write.
        if (succ_go) begin
          force_d[sc_addr]   = 1'b1;
          running_d[sc_addr] = 1'b1;
        end
        if (p_q == LAST) begin
          state_d = ST_RB;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = p_q + AW'(1);
          p_d       = p_q + AW'(1);
        end
      end
      ST_RB: begin
        // Read back the addressed timer once the walk has settled.
        mem_re    = ok_q;
        mem_raddr = idx_addr;
        state_d   = ST_CMD;
      end
      ST_CMD: begin
        if (cctb_op_e'(item_q.opcode) == OP_CLR_PEND) begin
          pend_vld_d = 1'b0;
        end
        res_d.expired_mask  = 16'(exp_q);
        res_d.pending       = pend_vld_d;
        res_d.pending_index = pend_vld_d ? pend_slot_d : 4'd0;
        res_d.running_mask  = 16'(running_d);
        res_d.running_count = run_cnt;
        res_d.sel_state     = ok_q ? upd_rec.mode : MODE_STOP;
        res_d.sel_hours     = ok_q ? upd_rec.current.h : 7'd0;
        res_d.sel_minutes   = ok_q ? upd_rec.current.m : 6'd0;
        res_d.sel_seconds   = ok_q ? upd_rec.current.s : 6'd0;
        state_d             = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      running_q   <= '0;
      force_q     <= '0;
      exp_q       <= '0;
      pend_vld_q  <= 1'b0;
      pend_slot_q <= '0;
      ok_q        <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      running_q   <= running_d;
      force_q     <= force_d;
      exp_q       <= exp_d;
      pend_vld_q  <= pend_vld_d;
      pend_slot_q <= pend_slot_d;
      ok_q        <= ok_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  // A run override only ever stands on a timer that counts as running.
  a_force_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (force_q & ~running_q) == '0)
    else $error("run override on a timer that is not running");

  // Any expiry seen in this tick has raised the pending flag.
  a_expiry_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|exp_q) |-> pend_vld_q)
    else $error("expiry recorded without pending flag");

  // The reported count agrees with the reported mask.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($countones(out_o.data.running_mask) ==
                     int'(out_o.data.running_count)))
    else $error("running count does not match running mask");
`endif

endmodule
